// ----- src/hhst_pkg.sv -----
// ----------------------------------------------------------------------------
// hhst_pkg
// Shared widths, codes, reset values and controller/datapath types for the
// hop history source time unit.
// ----------------------------------------------------------------------------
package hhst_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int MAX_FRAME_DEF     = 8192;

  localparam int TIME_W         = 64;
  localparam int HOP_W          = 16;
  localparam int WIN_IDX_W      = 13;
  localparam int WIN_VAL_W      = 17;
  localparam int FRAME_SIZE_W   = 14;
  localparam int HIST_CNT_W     = 7;
  localparam int PAD_W          = 14;
  localparam int ANCHOR_FRAME_W = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int FRAC_W         = 16;

  // quotient bits retired per divider cycle
  localparam int DIV_RADIX_BITS = 4;

  typedef enum logic [1:0] {
    ACT_COMMIT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_WINDOW = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_SIZE     = 3'd0,
    CFG_HISTORY_COUNT  = 3'd1,
    CFG_INPUT_PADDING  = 3'd2,
    CFG_OUTPUT_PADDING = 3'd3,
    CFG_IN_ANCHOR_FRM  = 3'd4,
    CFG_IN_ANCHOR_TIME = 3'd5,
    CFG_OUT_ANCHOR_FRM = 3'd6,
    CFG_OUT_ANCHOR_TIM = 3'd7
  } cfg_idx_t;

  localparam logic [FRAME_SIZE_W-1:0]   FRAME_SIZE_RST = 14'd1024;
  localparam logic [HIST_CNT_W-1:0]     HIST_CNT_RST   = 7'd4;
  localparam logic [PAD_W-1:0]          IN_PAD_RST     = 14'd1024;
  localparam logic [PAD_W-1:0]          OUT_PAD_RST    = 14'd0;
  localparam logic [ANCHOR_FRAME_W-1:0] IN_AFRM_RST    = -48'sd999999;
  localparam logic [TIME_W-1:0]         IN_ATIME_RST   = -64'sd65535934464;
  localparam logic [ANCHOR_FRAME_W-1:0] OUT_AFRM_RST   = 48'd0;
  localparam logic [TIME_W-1:0]         OUT_ATIME_RST  = 64'd0;

  typedef struct packed {
    logic commit;    // store a hop record, advance positions
    logic wwrite;    // write one window coefficient
    logic qload;     // capture query time
    logic frame;     // finish output frame, arm the scan
    logic issue;     // read next history record
    logic div_load;  // set up rounding division
    logic div_step;  // one divider iteration
    logic fin;       // form source time
    logic out_load;  // move result to output register
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_left;
    logic pipe_busy;
    logic div_done;
    logic wsum_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/hhst_if.sv -----
// ----------------------------------------------------------------------------
// hhst channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface hhst_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [hhst_pkg::HOP_W-1:0]        input_hop;
  logic [hhst_pkg::HOP_W-1:0]        output_hop;
  logic [hhst_pkg::TIME_W-1:0]       query_time;
  logic [hhst_pkg::WIN_IDX_W-1:0]    window_index;
  logic [hhst_pkg::WIN_VAL_W-1:0]    window_value;

  modport source (output valid, action, input_hop, output_hop, query_time,
                  window_index, window_value, input ready);
  modport sink   (input valid, action, input_hop, output_hop, query_time,
                  window_index, window_value, output ready);
endinterface

interface hhst_out_if;
  logic                          valid;
  logic                          ready;
  logic [hhst_pkg::TIME_W-1:0]   source_time;
  logic                          weight_found;

  modport source (output valid, source_time, weight_found, input ready);
  modport sink   (input valid, source_time, weight_found, output ready);
endinterface

interface hhst_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hhst_pkg::CFG_IDX_W-1:0]    index;
  logic [hhst_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/hop_history_source_time_unit.sv -----
// ----------------------------------------------------------------------------
// hop_history_source_time_unit
// Hop history ring and output-to-input time mapping for a time-stretch stream.
// ----------------------------------------------------------------------------
// Commits and window writes leave the sequencer idle, and the unit is ready
// again on the next cycle. During a query one record is read from the ring
// memory per cycle, a four-stage pipeline weights and accumulates them, and
// the rounding divider retires four quotient bits per cycle (23 iterations
// at the default depth). The result sits in an output register, so commits
// and window writes are taken while it waits. Register writes are taken in
// any cycle.
module hop_history_source_time_unit #(
  parameter int HISTORY_DEPTH = hhst_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_FRAME     = hhst_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hhst_in_if.sink     in_ch,
  hhst_out_if.source  out_ch,
  hhst_cfg_if.sink    cfg_ch
);
  import hhst_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  hhst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hhst_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_FRAME     (MAX_FRAME)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .input_hop    (in_ch.input_hop),
    .output_hop   (in_ch.output_hop),
    .query_time   (in_ch.query_time),
    .window_index (in_ch.window_index),
    .window_value (in_ch.window_value),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .source_time  (out_ch.source_time),
    .weight_found (out_ch.weight_found)
  );

endmodule

// ----- src/hhst_ram.sv -----
// ----------------------------------------------------------------------------
// hhst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hhst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/hhst_ctrl.sv -----
// ----------------------------------------------------------------------------
// hhst_ctrl
// Sequencer: accepts items, walks a query through frame, scan, drain, divide
// (skipped when the weight sum is zero) and result hand-off.
// ----------------------------------------------------------------------------
module hhst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_action,
  output logic                 in_ready,
  input  hhst_pkg::dp_status_t status,
  output hhst_pkg::ctl_cmd_t   cmd
);
  import hhst_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FRAME  = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_DRAIN  = 8'b0000_1000,
    ST_DIVSET = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_FINAL  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_action))
            ACT_COMMIT: cmd.commit = 1'b1;
            ACT_WINDOW: cmd.wwrite = 1'b1;
            ACT_QUERY: begin
              cmd.qload = 1'b1;
              state_nxt = ST_FRAME;
            end
            default: ;
          endcase
        end
      end
      ST_FRAME: begin
        cmd.frame = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_left) begin
          cmd.issue = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DIVSET;
        end
      end
      ST_DIVSET: begin
        // zero weight: skip the divider, source frame is zero
        if (status.wsum_zero) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.div_load = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FINAL: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/hhst_datapath.sv -----
// ----------------------------------------------------------------------------
// hhst_datapath
// Registers, hop record ring, window memory, scan pipeline, multiply and
// accumulate, rounding divider and output register.
// ----------------------------------------------------------------------------
module hhst_datapath #(
  parameter int HISTORY_DEPTH = hhst_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_FRAME     = hhst_pkg::MAX_FRAME_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hhst_pkg::ctl_cmd_t                cmd,
  output hhst_pkg::dp_status_t              status,
  input  logic [hhst_pkg::HOP_W-1:0]        input_hop,
  input  logic [hhst_pkg::HOP_W-1:0]        output_hop,
  input  logic [hhst_pkg::TIME_W-1:0]       query_time,
  input  logic [hhst_pkg::WIN_IDX_W-1:0]    window_index,
  input  logic [hhst_pkg::WIN_VAL_W-1:0]    window_value,
  input  logic                              cfg_we,
  input  logic [hhst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hhst_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hhst_pkg::TIME_W-1:0]       source_time,
  output logic                              weight_found
);
  import hhst_pkg::*;

  localparam int REC_AW    = $clog2(HISTORY_DEPTH);
  localparam int WIN_AW    = $clog2(MAX_FRAME);
  localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W     = 10;
  localparam int N_W       = 17;
  localparam int IDX_EXT_W = WIN_AW + WIN_IDX_W;
  localparam int ACC_W     = TIME_W + WIN_VAL_W + 1 + REC_AW;
  localparam int WS_W      = WIN_VAL_W + REC_AW;
  localparam int DV_W      = WS_W + 1;
  localparam int NUM_W     = ACC_W + 2;
  localparam int DIV_ITERS = (NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_W     = DIV_ITERS * DIV_RADIX_BITS;
  localparam int DIT_W     = $clog2(DIV_ITERS + 1);
  localparam int LO_W      = 32;
  localparam int PLO_W     = LO_W + WIN_VAL_W;
  localparam int PHI_W     = LO_W + WIN_VAL_W + 1;

  // configuration registers
  logic [FRAME_SIZE_W-1:0]   frame_size_r;
  logic [HIST_CNT_W-1:0]     hist_cnt_r;
  logic [PAD_W-1:0]          in_pad_r, out_pad_r;
  logic [ANCHOR_FRAME_W-1:0] iaf_r, oaf_r;
  logic [TIME_W-1:0]         iat_r, oat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RST;
      hist_cnt_r   <= HIST_CNT_RST;
      in_pad_r     <= IN_PAD_RST;
      out_pad_r    <= OUT_PAD_RST;
      iaf_r        <= IN_AFRM_RST;
      iat_r        <= IN_ATIME_RST;
      oaf_r        <= OUT_AFRM_RST;
      oat_r        <= OUT_ATIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_SIZE:     frame_size_r <= cfg_data[FRAME_SIZE_W-1:0];
        CFG_HISTORY_COUNT:  hist_cnt_r   <= cfg_data[HIST_CNT_W-1:0];
        CFG_INPUT_PADDING:  in_pad_r     <= cfg_data[PAD_W-1:0];
        CFG_OUTPUT_PADDING: out_pad_r    <= cfg_data[PAD_W-1:0];
        CFG_IN_ANCHOR_FRM:  iaf_r        <= cfg_data[ANCHOR_FRAME_W-1:0];
        CFG_IN_ANCHOR_TIME: iat_r        <= cfg_data;
        CFG_OUT_ANCHOR_FRM: oaf_r        <= cfg_data[ANCHOR_FRAME_W-1:0];
        CFG_OUT_ANCHOR_TIM: oat_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // hop record ring
  logic [TIME_W-1:0]        rd_pos_r, wr_pos_r;
  logic [REC_AW-1:0]        rec_idx_r, rec_idx_inc;
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic [2*TIME_W-1:0]      rec_wdata, rec_rdata;
  logic [TIME_W-1:0]        rec_in, rec_out;

  assign rec_idx_inc = (rec_idx_r == REC_AW'(HISTORY_DEPTH - 1)) ? '0 : rec_idx_r + 1'b1;
  assign rec_wdata   = {rd_pos_r - TIME_W'(in_pad_r), wr_pos_r - TIME_W'(out_pad_r)};
  assign rec_in      = rec_rdata[2*TIME_W-1:TIME_W];
  assign rec_out     = rec_rdata[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r  <= '0;
      wr_pos_r  <= '0;
      rec_idx_r <= '0;
      valid_r   <= '0;
    end else if (cmd.commit) begin
      rec_idx_r            <= rec_idx_inc;
      valid_r[rec_idx_inc] <= 1'b1;
      rd_pos_r             <= rd_pos_r + TIME_W'(input_hop);
      wr_pos_r             <= wr_pos_r + TIME_W'(output_hop);
    end
  end

  // scan pointer and query frame
  logic [REC_AW-1:0]  ptr_r;
  logic [CNT_W-1:0]   remain_r;
  logic [TIME_W-1:0]  diff_r, frame_r;
  logic [1:0]         adj_r;
  logic [N_W-1:0]     n_r;
  logic [17:0]        tfrac;
  logic [CNT_W-1:0]   count;
  logic [N_W-1:0]     n_clamp;

  assign tfrac   = {2'b00, query_time[FRAC_W-1:0]} + 18'd32768
                 - {2'b00, oat_r[FRAC_W-1:0]};
  assign count   = (CMP_W'(hist_cnt_r) > CMP_W'(HISTORY_DEPTH))
                 ? CNT_W'(HISTORY_DEPTH) : CNT_W'(hist_cnt_r);
  assign n_clamp = (N_W'(frame_size_r) > N_W'(MAX_FRAME))
                 ? N_W'(MAX_FRAME) : N_W'(frame_size_r);

  always_ff @(posedge clk) begin
    if (cmd.qload) begin
      diff_r <= {{FRAC_W{query_time[TIME_W-1]}}, query_time[TIME_W-1:FRAC_W]}
              - {{FRAC_W{oat_r[TIME_W-1]}}, oat_r[TIME_W-1:FRAC_W]};
      // round-half-up carry out of the fraction
      adj_r  <= tfrac[17] ? 2'b11 : (tfrac[16] ? 2'b01 : 2'b00);
    end
    if (cmd.frame) begin
      frame_r <= diff_r + {{(TIME_W-2){adj_r[1]}}, adj_r}
               + {{(TIME_W-ANCHOR_FRAME_W){oaf_r[ANCHOR_FRAME_W-1]}}, oaf_r};
      n_r     <= n_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
      ptr_r    <= '0;
    end else if (cmd.frame) begin
      remain_r <= count;
      ptr_r    <= rec_idx_r;
    end else if (cmd.issue) begin
      remain_r <= remain_r - 1'b1;
      ptr_r    <= (ptr_r == '0) ? REC_AW'(HISTORY_DEPTH - 1) : ptr_r - 1'b1;
    end
  end

  // scan pipeline: record read, window read, partial products, accumulate
  logic                 p1_r, p2_r, p3_r;
  logic                 v1_r, ok2_r;
  logic [TIME_W-1:0]    d, out_plus_n, x2_r;
  logic                 rec_ok;
  logic [WIN_VAL_W-1:0] win_rdata, w;
  logic [WIN_VAL_W-1:0] w3_r;
  logic [PLO_W-1:0]     plo_r;
  logic [PHI_W-1:0]     phi_r;
  logic [ACC_W-1:0]     acc_r, term;
  logic [WS_W-1:0]      wsum_r;

  assign d          = frame_r - rec_out;
  assign out_plus_n = rec_out + TIME_W'(n_r);
  assign rec_ok     = v1_r && !d[TIME_W-1] && ($signed(frame_r) < $signed(out_plus_n))
                    && (d < TIME_W'(MAX_FRAME));
  assign w          = ok2_r ? win_rdata : '0;
  assign term       = {{(ACC_W-PHI_W-LO_W){phi_r[PHI_W-1]}}, phi_r, {LO_W{1'b0}}}
                    + {{(ACC_W-PLO_W){1'b0}}, plo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
      p2_r <= 1'b0;
      p3_r <= 1'b0;
    end else begin
      p1_r <= cmd.issue;
      p2_r <= p1_r;
      p3_r <= p2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      v1_r <= valid_r[ptr_r];
    end
    if (p1_r) begin
      x2_r  <= rec_in + d;
      ok2_r <= rec_ok;
    end
    if (p2_r) begin
      plo_r <= x2_r[LO_W-1:0] * w;
      phi_r <= PHI_W'($signed(x2_r[TIME_W-1:LO_W]) * $signed({1'b0, w}));
      w3_r  <= w;
    end
    if (cmd.frame) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (p3_r) begin
      acc_r  <= acc_r + term;
      wsum_r <= wsum_r + WS_W'(w3_r);
    end
  end

  hhst_ram #(.WIDTH(2*TIME_W), .DEPTH(HISTORY_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (rec_idx_inc),
    .wdata (rec_wdata),
    .re    (cmd.issue),
    .raddr (ptr_r),
    .rdata (rec_rdata)
  );

  logic [IDX_EXT_W-1:0] widx_ext;
  logic                 win_we;

  assign widx_ext = IDX_EXT_W'(window_index);
  assign win_we   = cmd.wwrite && (widx_ext < IDX_EXT_W'(MAX_FRAME));

  hhst_ram #(.WIDTH(WIN_VAL_W), .DEPTH(MAX_FRAME)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (widx_ext[WIN_AW-1:0]),
    .wdata (window_value),
    .re    (p1_r),
    .raddr (d[WIN_AW-1:0]),
    .rdata (win_rdata)
  );

  // rounding divide: floor((2*sum_wx + sum_w) / (2*sum_w)), on magnitudes
  logic [NUM_W-1:0] num, mag;
  logic [DV_W-1:0]  dv;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DV_W-1:0]  dv_r, rem_r, rem_nxt;
  logic [DV_W:0]    trial;
  logic             neg_r;
  logic [DIT_W-1:0] dit_r;
  logic [TIME_W-1:0] q64, source;

  assign num = {acc_r[ACC_W-1], acc_r, 1'b0} + NUM_W'(wsum_r);
  assign dv  = {wsum_r, 1'b0};
  // negative side: -num + dv - 1
  assign mag = num[NUM_W-1] ? (~num + NUM_W'(dv)) : num;

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    trial   = '0;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      trial   = {rem_nxt, dvd_nxt[DIV_W-1]};
      dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dv_r}) begin
        trial      = trial - {1'b0, dv_r};
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r <= DIV_W'(mag);
      rem_r <= '0;
      dv_r  <= dv;
      neg_r <= num[NUM_W-1];
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dit_r <= '0;
    end else if (cmd.div_load) begin
      dit_r <= DIT_W'(DIV_ITERS);
    end else if (cmd.div_step) begin
      dit_r <= dit_r - 1'b1;
    end
  end

  assign q64    = dvd_r[TIME_W-1:0];
  assign source = (wsum_r == '0) ? '0 : (neg_r ? (~q64 + 1'b1) : q64);

  // result and output register
  logic [TIME_W-1:0] res_r, src_diff;
  logic              wf_r;
  logic              out_valid_r;
  logic [TIME_W-1:0] st_out_r;
  logic              wf_out_r;

  assign src_diff = source
                  - {{(TIME_W-ANCHOR_FRAME_W){iaf_r[ANCHOR_FRAME_W-1]}}, iaf_r};

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_r <= iat_r + {src_diff[TIME_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      wf_r  <= (wsum_r != '0);
    end
    if (cmd.out_load) begin
      st_out_r <= res_r;
      wf_out_r <= wf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign source_time  = st_out_r;
  assign weight_found = wf_out_r;

  assign status.scan_left = (remain_r != '0);
  assign status.pipe_busy = p1_r || p2_r || p3_r;
  assign status.div_done  = (dit_r == '0);
  assign status.wsum_zero = (wsum_r == '0);
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

// ----- src/hhst_chk.sv -----
// ----------------------------------------------------------------------------
// hhst_chk
// Port-level checks for the hop history source time unit, bound to the top.
// ----------------------------------------------------------------------------
module hhst_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   in_action,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [hhst_pkg::TIME_W-1:0]  source_time,
  input logic                         weight_found
);
  import hhst_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(source_time) && $stable(weight_found))
    else $error("result dropped or changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_QUERY) |=> !in_ready)
    else $error("input still ready right after a query transfer");

  a_other_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action != ACT_QUERY) |=> in_ready)
    else $error("commit or window write did not finish in one cycle");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while no query was in progress");

endmodule

bind hop_history_source_time_unit hhst_chk u_hhst_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .source_time  (out_ch.source_time),
  .weight_found (out_ch.weight_found)
);
